// ===== sv/c2fga_pkg.sv =====
// ----------------------------------------------------------------------------
// c2fga_pkg
// Shared types, constants and arithmetic helpers for the 2x2 convolution
// filter-gradient accumulator.
// ----------------------------------------------------------------------------
package c2fga_pkg;

  localparam int MAX_LINE    = 4096;
  localparam int SAMPLE_BITS = 16;
  localparam int SUM_BITS    = 48;
  localparam int PROD_BITS   = 2 * SAMPLE_BITS;
  localparam int COL_BITS    = $clog2(MAX_LINE);
  localparam int WIDTH_BITS  = 13;
  localparam int NUM_TAPS    = 4;
  localparam int TAP_BITS    = 2;

  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(256);
  localparam logic [WIDTH_BITS-1:0] WIDTH_MAX   = WIDTH_BITS'(MAX_LINE);
  localparam logic [TAP_BITS-1:0]   TAP_LAST    = TAP_BITS'(NUM_TAPS - 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;
  typedef logic [COL_BITS-1:0]           col_t;
  typedef logic [WIDTH_BITS-1:0]         width_t;
  typedef logic [TAP_BITS-1:0]           tap_idx_t;

  // One input transaction
  typedef struct packed {
    sample_t image_sample;
    sample_t grad_sample;
    logic    frame_start;
    logic    final_sample;
  } in_item_t;

  // One result transaction
  typedef struct packed {
    logic tap_row;
    logic tap_col;
    sum_t gradient_sum;
    logic last_tap;
  } out_item_t;

  // Saturating add of a product into an accumulator
  function automatic sum_t sat_add(input sum_t acc, input prod_t p);
    logic signed [SUM_BITS:0] wide;
    sum_t                     res;
    wide = {acc[SUM_BITS-1], acc} + (SUM_BITS+1)'(p);
    if (wide[SUM_BITS] != wide[SUM_BITS-1]) begin
      res = wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
    end else begin
      res = wide[SUM_BITS-1:0];
    end
    return res;
  endfunction

  // Clamp the programmed line width into 1..MAX_LINE
  function automatic width_t eff_width(input width_t w);
    width_t res;
    if (w == '0) begin
      res = width_t'(1);
    end else if (w > WIDTH_MAX) begin
      res = WIDTH_MAX;
    end else begin
      res = w;
    end
    return res;
  endfunction

endpackage

// ===== sv/c2fga_line_buffer.sv =====
// ----------------------------------------------------------------------------
// c2fga_line_buffer
// Previous-row sample store. One access per cycle reads the old entry and
// writes the new sample at the same column; read data is registered.
// ----------------------------------------------------------------------------
module c2fga_line_buffer
  import c2fga_pkg::*;
(
  input  logic    clk,
  input  logic    access_en,
  input  col_t    addr,
  input  sample_t wr_data,
  output sample_t rd_data
);

  sample_t mem [MAX_LINE];

  // Read old contents, then overwrite with the current sample
  always_ff @(posedge clk) begin
    if (access_en) begin
      rd_data   <= mem[addr];
      mem[addr] <= wr_data;
    end
  end

endmodule

// ===== sv/conv2x2_filter_gradient_accum.sv =====
// ----------------------------------------------------------------------------
// conv2x2_filter_gradient_accum
// Weight gradient of a 2x2 stride-1 convolution: four saturating
// multiply-accumulates per sample pair, emitted on the final sample.
// ----------------------------------------------------------------------------
// Throughput: one sample transaction per cycle while sample_stall is low;
// the line buffer port is read and written once per sample.
// Emission: result_valid rises once the final sample has passed stages 1 and 2
// into emit_buf; the four taps follow on consecutive unstalled cycles.
// Input stalls only while a final sample waits for the previous emission.
// Reset: sums cleared, width 256, position row 0 column 0; row store kept.
// ----------------------------------------------------------------------------
module conv2x2_filter_gradient_accum
  import c2fga_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_write,
  input  width_t    cfg_data,
  input  logic      sample_valid,
  output logic      sample_stall,
  input  in_item_t  sample,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result
);

  // Configuration and position state
  width_t  line_width;
  col_t    column_count;
  logic    on_first_row;
  sample_t left_sample;
  sample_t upper_left;

  // Stage 1: line buffer read in flight
  logic    s1_valid;
  logic    s1_final;
  logic    s1_first;
  logic    s1_col_zero;
  sample_t s1_here;
  sample_t s1_left;
  sample_t s1_grad;
  sample_t above_raw;

  // Stage 2: products
  logic    s2_valid;
  logic    s2_final;
  prod_t   s2_prod [NUM_TAPS];

  // Accumulators and emission buffer
  sum_t     tap_sums  [NUM_TAPS];
  sum_t     sums_next [NUM_TAPS];
  sum_t     emit_buf  [NUM_TAPS];
  logic     emit_busy;
  tap_idx_t emit_idx;

  logic    advance;
  logic    accept;
  logic    buf_free;
  width_t  w;
  col_t    col;
  logic    first_row;
  width_t  col_inc;
  sample_t above;
  sample_t ul;

  // Pipeline control
  assign buf_free     = !emit_busy || (!result_stall && emit_idx == TAP_LAST);
  assign advance      = !(s2_valid && s2_final && !buf_free);
  assign sample_stall = !advance;
  assign accept       = sample_valid && advance;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= WIDTH_RESET;
    end else if (cfg_write) begin
      line_width <= cfg_data;
    end
  end

  // Work out the column of the current sample
  always_comb begin
    w         = eff_width(line_width);
    col       = sample.frame_start ? '0 : column_count;
    first_row = sample.frame_start ? 1'b1 : on_first_row;
    if (width_t'(col) >= w) begin
      col       = '0;
      first_row = 1'b0;
    end
    col_inc = width_t'(col) + width_t'(1);
  end

  // Advance raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      on_first_row <= 1'b1;
    end else if (accept) begin
      if (sample.final_sample) begin
        column_count <= '0;
        on_first_row <= 1'b1;
      end else if (col_inc >= w) begin
        column_count <= '0;
        on_first_row <= 1'b0;
      end else begin
        column_count <= col_inc[COL_BITS-1:0];
        on_first_row <= first_row;
      end
    end
  end

  c2fga_line_buffer u_line_buffer (
    .clk       (clk),
    .access_en (accept),
    .addr      (col),
    .wr_data   (sample.image_sample),
    .rd_data   (above_raw)
  );

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      left_sample <= '0;
    end else if (advance) begin
      s1_valid <= accept;
      if (accept) begin
        left_sample <= sample.image_sample;
      end
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_final    <= sample.final_sample;
      s1_first    <= first_row;
      s1_col_zero <= (col == '0);
      s1_here     <= sample.image_sample;
      s1_left     <= (col == '0) ? '0 : left_sample;
      s1_grad     <= sample.grad_sample;
    end
  end

  // Mask taps that fall outside the image
  assign above = s1_first ? '0 : above_raw;
  assign ul    = (s1_first || s1_col_zero) ? '0 : upper_left;

  // Stage 2 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid   <= 1'b0;
      upper_left <= '0;
    end else if (advance) begin
      s2_valid <= s1_valid;
      if (s1_valid) begin
        upper_left <= above;
      end
    end
  end

  // Multiply taps by the gradient sample
  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      s2_final  <= s1_final;
      s2_prod[0] <= ul * s1_grad;
      s2_prod[1] <= above * s1_grad;
      s2_prod[2] <= s1_left * s1_grad;
      s2_prod[3] <= s1_here * s1_grad;
    end
  end

  // Saturating accumulate
  always_comb begin
    for (int k = 0; k < NUM_TAPS; k++) begin
      sums_next[k] = sat_add(tap_sums[k], s2_prod[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_TAPS; k++) begin
        tap_sums[k] <= '0;
      end
    end else if (advance && s2_valid) begin
      for (int k = 0; k < NUM_TAPS; k++) begin
        tap_sums[k] <= s2_final ? '0 : sums_next[k];
      end
    end
  end

  // Snapshot sums for emission
  always_ff @(posedge clk) begin
    if (advance && s2_valid && s2_final) begin
      for (int k = 0; k < NUM_TAPS; k++) begin
        emit_buf[k] <= sums_next[k];
      end
    end
  end

  // Step through the four taps
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_busy <= 1'b0;
      emit_idx  <= '0;
    end else begin
      if (emit_busy && !result_stall) begin
        emit_idx <= emit_idx + tap_idx_t'(1);
        if (emit_idx == TAP_LAST) begin
          emit_busy <= 1'b0;
        end
      end
      if (advance && s2_valid && s2_final) begin
        emit_busy <= 1'b1;
        emit_idx  <= '0;
      end
    end
  end

  // Drive result transaction
  assign result_valid        = emit_busy;
  assign result.tap_row      = emit_idx[1];
  assign result.tap_col      = emit_idx[0];
  assign result.gradient_sum = emit_buf[emit_idx];
  assign result.last_tap     = (emit_idx == TAP_LAST);

endmodule
